// ----- rtl/core/vpsp_pkg.sv -----
// ----------------------------------------------------------------------------
// vpsp_pkg
// Shared types and constants of the view point to screen projection block.
// ----------------------------------------------------------------------------
package vpsp_pkg;

    localparam int unsigned DivSteps = 32;

    localparam logic [1:0] StBehind    = 2'd0;
    localparam logic [1:0] StOffScreen = 2'd1;
    localparam logic [1:0] StOnScreen  = 2'd2;

    localparam logic [2:0] RegXScale  = 3'd0;
    localparam logic [2:0] RegXOffset = 3'd1;
    localparam logic [2:0] RegYScale  = 3'd2;
    localparam logic [2:0] RegYOffset = 3'd3;
    localparam logic [2:0] RegTop     = 3'd4;
    localparam logic [2:0] RegLeft    = 3'd5;
    localparam logic [2:0] RegBottom  = 3'd6;
    localparam logic [2:0] RegRight   = 3'd7;

    localparam logic signed [31:0] OneQ16 = 32'sd65536;
    localparam logic signed [31:0] MaxS32 = 32'sh7fffffff;
    localparam logic signed [31:0] MinS32 = 32'sh80000000;

    // control that travels beside the payload
    typedef struct packed {
        logic vld;
        logic behind;
    } t_ctl;

    function automatic logic [31:0] mag32(input logic [31:0] v);
        return v[31] ? 32'(-v) : v;
    endfunction

endpackage

// ----- rtl/core/vpsp_num.sv -----
// ----------------------------------------------------------------------------
// vpsp_num
// Numerator of one axis: two 32x32 magnitude products, then their signed sum
// as sign and magnitude, with the divisor and a quotient overflow flag.
// ----------------------------------------------------------------------------
module vpsp_num (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  vpsp_pkg::t_ctl i_ctl,
    input  logic        i_negate,
    input  logic [31:0] i_scale,
    input  logic [31:0] i_coord,
    input  logic [31:0] i_offset,
    input  logic [31:0] i_z,
    output vpsp_pkg::t_ctl o_ctl,
    output logic [63:0] o_num,
    output logic [31:0] o_den,
    output logic        o_neg,
    output logic        o_ovf
);

    vpsp_pkg::t_ctl r_ctl1, r_ctl2;
    logic [63:0] r_m1, r_m2, r_num;
    logic        r_n1, r_n2, r_neg;
    logic [31:0] r_den1, r_den2;
    logic        r_ovf;
    logic [63:0] n_num;
    logic        n_neg;

    always_comb begin
        if (r_n1 == r_n2) begin
            n_num = r_m1 + r_m2;
            n_neg = r_n1;
        end else if (r_m1 >= r_m2) begin
            n_num = r_m1 - r_m2;
            n_neg = r_n1;
        end else begin
            n_num = r_m2 - r_m1;
            n_neg = r_n2;
        end
        n_neg = n_neg ^ i_negate;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
            r_ctl2 <= '0;
        end else if (i_en) begin
            r_ctl1 <= i_ctl;
            r_ctl2 <= r_ctl1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m1   <= {32'd0, vpsp_pkg::mag32(i_scale)} * {32'd0, vpsp_pkg::mag32(i_coord)};
            r_m2   <= {32'd0, vpsp_pkg::mag32(i_offset)} * {32'd0, vpsp_pkg::mag32(i_z)};
            r_n1   <= i_scale[31] ^ i_coord[31];
            r_n2   <= i_offset[31] ^ i_z[31];
            r_den1 <= vpsp_pkg::mag32(i_z);
            r_num  <= n_num;
            r_neg  <= n_neg;
            r_den2 <= r_den1;
            // quotient of 2^32 or more saturates either way
            r_ovf  <= n_num[63:32] >= r_den1;
        end
    end

    assign o_ctl = r_ctl2;
    assign o_num = r_num;
    assign o_den = r_den2;
    assign o_neg = r_neg;
    assign o_ovf = r_ovf;

endmodule

// ----- rtl/core/vpsp_div.sv -----
// ----------------------------------------------------------------------------
// vpsp_div
// Pipelined restoring divider, one quotient bit per stage, 32 stages.
// ----------------------------------------------------------------------------
module vpsp_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  vpsp_pkg::t_ctl i_ctl,
    input  logic [63:0] i_num,
    input  logic [31:0] i_den,
    input  logic        i_neg,
    input  logic        i_ovf,
    output vpsp_pkg::t_ctl o_ctl,
    output logic [31:0] o_quo,
    output logic        o_neg,
    output logic        o_ovf
);

    localparam int unsigned N = vpsp_pkg::DivSteps;

    vpsp_pkg::t_ctl r_ctl [N];
    logic [31:0] r_rem [N];
    logic [31:0] r_num [N];
    logic [31:0] r_quo [N];
    logic [31:0] r_den [N];
    logic        r_neg [N];
    logic        r_ovf [N];

    for (genvar i = 0; i < N; i++) begin : g_step
        vpsp_pkg::t_ctl p_ctl;
        logic [31:0] p_rem, p_num, p_quo, p_den;
        logic        p_neg, p_ovf;
        logic [32:0] t;
        logic        ge;

        if (i == 0) begin : g_first
            assign p_ctl = i_ctl;
            assign p_rem = i_num[63:32];
            assign p_num = i_num[31:0];
            assign p_quo = '0;
            assign p_den = i_den;
            assign p_neg = i_neg;
            assign p_ovf = i_ovf;
        end else begin : g_next
            assign p_ctl = r_ctl[i-1];
            assign p_rem = r_rem[i-1];
            assign p_num = r_num[i-1];
            assign p_quo = r_quo[i-1];
            assign p_den = r_den[i-1];
            assign p_neg = r_neg[i-1];
            assign p_ovf = r_ovf[i-1];
        end

        assign t  = {p_rem, p_num[31]};
        assign ge = t >= {1'b0, p_den};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[i] <= '0;
            end else if (i_en) begin
                r_ctl[i] <= p_ctl;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[i] <= ge ? 32'(t - {1'b0, p_den}) : t[31:0];
                r_num[i] <= {p_num[30:0], 1'b0};
                r_quo[i] <= {p_quo[30:0], ge};
                r_den[i] <= p_den;
                r_neg[i] <= p_neg;
                r_ovf[i] <= p_ovf;
            end
        end
    end

    assign o_ctl = r_ctl[N-1];
    assign o_quo = r_quo[N-1];
    assign o_neg = r_neg[N-1];
    assign o_ovf = r_ovf[N-1];

endmodule

// ----- rtl/core/vpsp_map.sv -----
// ----------------------------------------------------------------------------
// vpsp_map
// Saturates the NDC pair, tests it against [-1,1] and maps an on-screen pair
// into the viewport; the last stage is the output register.
// ----------------------------------------------------------------------------
module vpsp_map (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  vpsp_pkg::t_ctl i_ctl,
    input  logic [31:0] i_qx,
    input  logic        i_negx,
    input  logic        i_ovfx,
    input  logic [31:0] i_qy,
    input  logic        i_negy,
    input  logic        i_ovfy,
    input  logic [15:0] i_top,
    input  logic [15:0] i_left,
    input  logic [15:0] i_bottom,
    input  logic [15:0] i_right,
    output logic        o_vld,
    output logic [1:0]  o_status,
    output logic [31:0] o_x,
    output logic [31:0] o_y
);

    function automatic logic signed [31:0] sat_q(input logic [31:0] q, input logic neg,
                                                 input logic ovf);
        if (neg)
            return (ovf || q[31]) ? vpsp_pkg::MinS32 : 32'(-q);
        return (ovf || q[31]) ? vpsp_pkg::MaxS32 : q;
    endfunction

    function automatic logic in_ndc(input logic signed [31:0] v);
        return v >= -vpsp_pkg::OneQ16 && v <= vpsp_pkg::OneQ16;
    endfunction

    function automatic logic signed [31:0] place(input logic signed [35:0] prod,
                                                 input logic signed [15:0] lo);
        logic signed [36:0] p;
        logic signed [35:0] h;
        p = 37'(prod) + (37'(lo) <<< 17);
        h = 36'(p >>> 1);
        if (h > 36'(vpsp_pkg::MaxS32)) return vpsp_pkg::MaxS32;
        if (h < 36'(vpsp_pkg::MinS32)) return vpsp_pkg::MinS32;
        return h[31:0];
    endfunction

    logic n_nx_sgn, n_ny_sgn;
    logic signed [31:0] n_nx, n_ny;

    vpsp_pkg::t_ctl r_ctl_a, r_ctl_b;
    logic signed [31:0] r_nx_a, r_ny_a, r_nx_b, r_ny_b;
    logic        r_on_a, r_on_b;
    logic signed [35:0] r_px, r_py;
    logic signed [15:0] r_left, r_top;
    logic        r_vld;
    logic [1:0]  r_status;
    logic [31:0] r_x, r_y;

    assign n_nx_sgn = i_negx;
    assign n_ny_sgn = i_negy;
    assign n_nx = sat_q(i_qx, n_nx_sgn, i_ovfx);
    assign n_ny = sat_q(i_qy, n_ny_sgn, i_ovfy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl_a <= '0;
            r_ctl_b <= '0;
            r_vld   <= 1'b0;
        end else if (i_en) begin
            r_ctl_a <= i_ctl;
            r_ctl_b <= r_ctl_a;
            r_vld   <= r_ctl_b.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_nx_a <= n_nx;
            r_ny_a <= n_ny;
            r_on_a <= in_ndc(n_nx) && in_ndc(n_ny);

            // width (17 bit) times ndc+1 (18 bit, 0..2^17)
            r_px   <= 36'(($signed({i_right[15], i_right}) - $signed({i_left[15], i_left}))
                       * $signed({1'b0, 18'(r_nx_a + vpsp_pkg::OneQ16)}));
            r_py   <= 36'(($signed({i_bottom[15], i_bottom}) - $signed({i_top[15], i_top}))
                       * $signed({1'b0, 18'(r_ny_a + vpsp_pkg::OneQ16)}));
            r_left <= i_left;
            r_top  <= i_top;
            r_nx_b <= r_nx_a;
            r_ny_b <= r_ny_a;
            r_on_b <= r_on_a;

            if (r_ctl_b.behind) begin
                r_status <= vpsp_pkg::StBehind;
                r_x      <= '0;
                r_y      <= '0;
            end else if (r_on_b) begin
                r_status <= vpsp_pkg::StOnScreen;
                r_x      <= place(r_px, r_left);
                r_y      <= place(r_py, r_top);
            end else begin
                r_status <= vpsp_pkg::StOffScreen;
                r_x      <= r_nx_b;
                r_y      <= r_ny_b;
            end
        end
    end

    assign o_vld    = r_vld;
    assign o_status = r_status;
    assign o_x      = r_x;
    assign o_y      = r_y;

endmodule

// ----- rtl/core/view_point_to_screen_projection.sv -----
// ----------------------------------------------------------------------------
// view_point_to_screen_projection
// Projects view-space points (Q16.16) to NDC or viewport pixel coordinates.
// ----------------------------------------------------------------------------
// Input stream: one beat per point, tdata = view_x, view_y, view_z.
// Output stream: one beat per point, tdata = screen_x, screen_y and
// tuser = status (behind camera, off screen, on screen).
// Configuration: write channel with register index and data; indexes past
// the list are dropped. Write only while no point is in flight.
// Each point passes through the numerator products and sum, the divider (one
// quotient bit per stage), then saturation, the viewport multiply and the
// final add into the output register.
// Throughput is one point per cycle. The whole pipeline advances while the
// output register is empty or being taken; when the receiver stalls with a
// beat held, every stage holds and the input tready drops.
// Reset clears all valid bits, holds both ready outputs low, and loads the
// projection with unit scale and zero offsets, and the viewport with zeros.
// ----------------------------------------------------------------------------
module view_point_to_screen_projection (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [95:0] i_s_tdata,   // view_x, view_y, view_z
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata,   // screen_x, screen_y
    output logic [1:0]  o_m_tuser,   // status
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    logic [31:0] r_xs, r_xo, r_ys, r_yo;
    logic [15:0] r_top, r_left, r_bottom, r_right;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xs     <= vpsp_pkg::OneQ16;
            r_xo     <= '0;
            r_ys     <= vpsp_pkg::OneQ16;
            r_yo     <= '0;
            r_top    <= '0;
            r_left   <= '0;
            r_bottom <= '0;
            r_right  <= '0;
        end else if (i_cfg_valid && i_cfg_index[7:3] == 5'd0) begin
            case (i_cfg_index[2:0])
                vpsp_pkg::RegXScale:  r_xs     <= i_cfg_data;
                vpsp_pkg::RegXOffset: r_xo     <= i_cfg_data;
                vpsp_pkg::RegYScale:  r_ys     <= i_cfg_data;
                vpsp_pkg::RegYOffset: r_yo     <= i_cfg_data;
                vpsp_pkg::RegTop:     r_top    <= i_cfg_data[15:0];
                vpsp_pkg::RegLeft:    r_left   <= i_cfg_data[15:0];
                vpsp_pkg::RegBottom:  r_bottom <= i_cfg_data[15:0];
                vpsp_pkg::RegRight:   r_right  <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // a write during reset would be dropped, so it is not taken
    assign o_cfg_ready = i_rst_n;

    logic en;
    vpsp_pkg::t_ctl in_ctl, numx_ctl, divx_ctl;
    logic [63:0] numx, numy;
    logic [31:0] denx, deny, qx, qy;
    logic        negx_n, negy_n, ovfx_n, ovfy_n;
    logic        negx_d, negy_d, ovfx_d, ovfy_d;

    assign en         = !o_m_tvalid || i_m_tready;
    assign o_s_tready = en && i_rst_n;
    assign in_ctl.vld    = i_s_tvalid;
    assign in_ctl.behind = !i_s_tdata[95];

    vpsp_num u_num_x (
        .i_clk, .i_rst_n, .i_en(en), .i_ctl(in_ctl), .i_negate(1'b0),
        .i_scale(r_xs), .i_coord(i_s_tdata[31:0]), .i_offset(r_xo), .i_z(i_s_tdata[95:64]),
        .o_ctl(numx_ctl), .o_num(numx), .o_den(denx), .o_neg(negx_n), .o_ovf(ovfx_n)
    );

    vpsp_num u_num_y (
        .i_clk, .i_rst_n, .i_en(en), .i_ctl(in_ctl), .i_negate(1'b1),
        .i_scale(r_ys), .i_coord(i_s_tdata[63:32]), .i_offset(r_yo), .i_z(i_s_tdata[95:64]),
        .o_ctl(), .o_num(numy), .o_den(deny), .o_neg(negy_n), .o_ovf(ovfy_n)
    );

    vpsp_div u_div_x (
        .i_clk, .i_rst_n, .i_en(en), .i_ctl(numx_ctl),
        .i_num(numx), .i_den(denx), .i_neg(negx_n), .i_ovf(ovfx_n),
        .o_ctl(divx_ctl), .o_quo(qx), .o_neg(negx_d), .o_ovf(ovfx_d)
    );

    vpsp_div u_div_y (
        .i_clk, .i_rst_n, .i_en(en), .i_ctl(numx_ctl),
        .i_num(numy), .i_den(deny), .i_neg(negy_n), .i_ovf(ovfy_n),
        .o_ctl(), .o_quo(qy), .o_neg(negy_d), .o_ovf(ovfy_d)
    );

    vpsp_map u_map (
        .i_clk, .i_rst_n, .i_en(en), .i_ctl(divx_ctl),
        .i_qx(qx), .i_negx(negx_d), .i_ovfx(ovfx_d),
        .i_qy(qy), .i_negy(negy_d), .i_ovfy(ovfy_d),
        .i_top(r_top), .i_left(r_left), .i_bottom(r_bottom), .i_right(r_right),
        .o_vld(o_m_tvalid), .o_status(o_m_tuser),
        .o_x(o_m_tdata[31:0]), .o_y(o_m_tdata[63:32])
    );

endmodule

// ----- tb/vpsp_checker.sv -----
// ----------------------------------------------------------------------------
// vpsp_checker
// Watches the point, result and register write channels, predicts each
// projected result and compares it field by field with what the block sends.
// ----------------------------------------------------------------------------
module vpsp_checker
    import vpsp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [95:0] i_s_tdata,   // view_x, view_y, view_z
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [63:0] i_m_tdata,   // screen_x, screen_y
    input  logic [1:0]  i_m_tuser,   // status
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] sx;
        logic [31:0] sy;
    } t_proj;

    t_proj expected_q[$];
    logic signed [31:0] x_scale, x_offset, y_scale, y_offset;
    logic signed [15:0] vp_top, vp_left, vp_bottom, vp_right;

    assign o_pending = expected_q.size();

    // (s*a + o*z) / -z with truncation; negation before saturation
    function automatic logic signed [31:0] ndc(input logic signed [31:0] s,
            input logic signed [31:0] a, input logic signed [31:0] o,
            input logic signed [31:0] z, input bit neg);
        logic signed [65:0] num;
        logic signed [65:0] q;
        num = 66'(s) * 66'(a) + 66'(o) * 66'(z);
        if (neg) num = -num;
        q = num / (-66'(z));
        if (q > 66'sd2147483647) return MaxS32;
        if (q < -66'sd2147483648) return MinS32;
        return q[31:0];
    endfunction

    function automatic logic signed [31:0] pixel(input logic signed [31:0] n,
            input logic signed [15:0] lo, input logic signed [15:0] hi);
        logic signed [63:0] p;
        p = (64'(hi) - 64'(lo)) * (64'(n) + 64'sd65536) + 64'(lo) * 64'sd131072;
        p = p >>> 1;  // floor
        if (p > 64'sd2147483647) return MaxS32;
        if (p < -64'sd2147483648) return MinS32;
        return p[31:0];
    endfunction

    function automatic t_proj project(input logic [95:0] pt);
        logic signed [31:0] vx, vy, vz, nx, ny;
        t_proj r;
        vx = pt[31:0];
        vy = pt[63:32];
        vz = pt[95:64];
        if (vz >= 0) return '{StBehind, 32'd0, 32'd0};
        nx = ndc(x_scale, vx, x_offset, vz, 1'b0);
        ny = ndc(y_scale, vy, y_offset, vz, 1'b1);
        if (nx >= -OneQ16 && nx <= OneQ16 && ny >= -OneQ16 && ny <= OneQ16)
            r = '{StOnScreen, pixel(nx, vp_left, vp_right), pixel(ny, vp_top, vp_bottom)};
        else
            r = '{StOffScreen, nx, ny};
        return r;
    endfunction

    task automatic report(input string what, input logic [31:0] got,
            input logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
        o_fail_count++;
    endtask

    initial o_fail_count = 0;

    always @(posedge i_clk) begin
        t_proj want;
        if (!i_rst_n) begin
            x_scale <= OneQ16; x_offset <= '0; y_scale <= OneQ16; y_offset <= '0;
            vp_top <= '0; vp_left <= '0; vp_bottom <= '0; vp_right <= '0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    8'(RegXScale):  x_scale   <= i_cfg_data;
                    8'(RegXOffset): x_offset  <= i_cfg_data;
                    8'(RegYScale):  y_scale   <= i_cfg_data;
                    8'(RegYOffset): y_offset  <= i_cfg_data;
                    8'(RegTop):     vp_top    <= i_cfg_data[15:0];
                    8'(RegLeft):    vp_left   <= i_cfg_data[15:0];
                    8'(RegBottom):  vp_bottom <= i_cfg_data[15:0];
                    8'(RegRight):   vp_right  <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) expected_q.push_back(project(i_s_tdata));
            if (i_m_tvalid && i_m_tready) begin
                if (expected_q.size() == 0) begin
                    report("unexpected beat", i_m_tdata[31:0], 32'd0);
                end else begin
                    want = expected_q.pop_front();
                    if (i_m_tuser != want.status) report("status", 32'(i_m_tuser), 32'(want.status));
                    if (i_m_tdata[31:0] != want.sx) report("screen_x", i_m_tdata[31:0], want.sx);
                    if (i_m_tdata[63:32] != want.sy) report("screen_y", i_m_tdata[63:32], want.sy);
                end
            end
        end
    end
endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Drives points and register writes into the projection block, with random
// stalls on both streams, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb
    import vpsp_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int Latency = 37;
    localparam longint CycleLimit = 400000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    int          fail_count, pending;
    longint      cycles = 0;
    bit          calm = 1'b0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    view_point_to_screen_projection u_dut (
        .i_clk, .i_rst_n,
        .i_s_tvalid(s_tvalid), .o_s_tready(s_tready), .i_s_tdata(s_tdata),
        .o_m_tvalid(m_tvalid), .i_m_tready(m_tready), .o_m_tdata(m_tdata),
        .o_m_tuser(m_tuser),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    vpsp_checker u_checker (
        .i_clk, .i_rst_n,
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready), .i_s_tdata(s_tdata),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready), .i_m_tdata(m_tdata),
        .i_m_tuser(m_tuser),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("view_point_to_screen_projection regression: fail");
            $finish;
        end
    end

    // receiver stalls in bursts
    always @(posedge i_clk) begin
        int stall;
        if (calm || $urandom_range(0, 5) != 0) begin
            m_tready <= 1'b1;
        end else begin
            stall = $urandom_range(1, 5);
            m_tready <= 1'b0;
            repeat (stall) @(posedge i_clk);
            m_tready <= 1'b1;
        end
    end

    task automatic write_reg(input logic [7:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending != 0) @(posedge i_clk);
        repeat (Latency + 4) @(posedge i_clk);
    endtask

    task automatic send_point(input logic [31:0] vx, input logic [31:0] vy,
            input logic [31:0] vz);
        if (!calm && $urandom_range(0, 6) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {vz, vy, vx};
        do @(posedge i_clk); while (!s_tready);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
            2: return {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom())};
            3: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
            default: return 32'($signed($urandom_range(0, 1 << 25)) - (1 << 24));
        endcase
    endfunction

    // z is mostly in front of the camera and of a similar scale to x and y
    function automatic logic [31:0] rand_depth();
        case ($urandom_range(0, 7))
            0: return $urandom();
            1: return 32'd0;
            2: return 32'h8000_0000;
            3: return 32'($urandom_range(0, 1 << 16));
            default: return 32'(-$signed($urandom_range(1, 1 << 25)));
        endcase
    endfunction

    task automatic load_setting(input int kind);
        logic [31:0] v [8];
        case (kind)
            0: v = '{32'h0001_0000, 32'd0, 32'h0001_0000, 32'd0,
                     32'd0, 32'd0, 32'd1080, 32'd1920};
            1: v = '{32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                     32'h8000, 32'h7fff, 32'h7fff, 32'h8000};
            2: v = '{32'h0001_0000, 32'h0000_8000, 32'hffff_0000, 32'hffff_c000,
                     32'd480, 32'd640, 32'd0, 32'd0};
            default: begin
                for (int i = 0; i < 4; i++)
                    v[i] = $urandom_range(0, 3) == 0 ? $urandom()
                         : 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
                for (int i = 4; i < 8; i++) v[i] = $urandom();
            end
        endcase
        write_reg(8'(RegXScale),  v[0]);
        write_reg(8'(RegXOffset), v[1]);
        write_reg(8'(RegYScale),  v[2]);
        write_reg(8'(RegYOffset), v[3]);
        write_reg(8'(RegTop),     v[4]);
        write_reg(8'(RegLeft),    v[5]);
        write_reg(8'(RegBottom),  v[6]);
        write_reg(8'(RegRight),   v[7]);
        write_reg(8'd200, $urandom());  // past the register list, dropped
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: default registers, then a real viewport
        send_point(32'd0, 32'd0, 32'd0);                  // z zero, behind
        send_point(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
        send_point(32'd0, 32'd0, 32'hffff_0000);          // center
        send_point(32'h0001_0000, 32'hffff_0000, 32'hffff_0000); // corner, ndc = +1 on both axes
        send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'hffff_ffff); // overflow saturates
        send_point(32'h8000_0000, 32'h8000_0000, 32'hffff_ffff);
        send_point(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
        send_point(32'h0001_0001, 32'd0, 32'hffff_0000);  // just off screen
        s_tvalid <= 1'b0;
        drain();
        for (int k = 0; k < 3; k++) begin
            load_setting(k);
            send_point(32'd0, 32'd0, 32'hffff_0000);
            send_point(32'h0001_0000, 32'h0001_0000, 32'hffff_0000);
            send_point(32'hffff_0000, 32'hffff_0000, 32'hffff_0000);
            send_point(32'h0000_4000, 32'hffff_8000, 32'hfffe_0000);
            send_point(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000);
            s_tvalid <= 1'b0;
            drain();  // also the sender waiting for every result
        end

        // random phases over random and extreme settings
        for (int ph = 0; ph < 12; ph++) begin
            load_setting(ph < 2 ? ph : (ph % 4 == 0 ? 2 : 3));
            if (ph == 11) calm = 1'b1;
            for (int n = 0; n < 140; n++) begin
                if ($urandom_range(0, 2) == 0)
                    send_point($urandom(), $urandom(), rand_depth());
                else
                    send_point(rand_coord(), rand_coord(), rand_depth());
            end
            s_tvalid <= 1'b0;
            drain();
        end

        if (fail_count == 0)
            $display("view_point_to_screen_projection regression: pass");
        else
            $display("view_point_to_screen_projection regression: fail");
        $finish;
    end
endmodule
